// ===== design/mbet_pkg.sv =====
package mbet_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned ITER_W  = 7;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

  localparam logic signed [VAL_W-1:0] REAL_ORIGIN_RST = -32'sd536870912;
  localparam logic signed [VAL_W-1:0] IMAG_ORIGIN_RST = 32'sd300647711;
  localparam logic [STEP_W-1:0]       REAL_STEP_RST   = 31'd2762648;
  localparam logic [STEP_W-1:0]       IMAG_STEP_RST   = 31'd4454040;
  localparam logic [ITER_W-1:0]       MAX_ITER_RST    = 7'd127;

  localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'd255;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [ITER_W-1:0]  iter_count;
    logic               escaped;
    logic [GRAY_W-1:0]  gray_level;
  } pix_out_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

// ===== design/mbet_mul.sv =====
module mbet_mul
  import mbet_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [VAL_W-1:0]  a_i,
  input  logic signed [VAL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/mandelbrot_escape_time_core.sv =====
// Mandelbrot escape-time evaluator. Each item is a pixel (column, row); it is mapped to
// c = (real_origin + col*real_step, imag_origin - row*imag_step) in signed fixed point
// with FRAC_BITS fraction bits, then z = z^2 + c is iterated from z = c until |z|^2 > 4
// or max_iterations is reached. One registered 32x32 multiplier is shared by all
// products: mapping runs through states S_CR, S_CI and S_CINIT, and each escape test
// through S_MRR, S_MII, S_MRI and S_UPD (three products plus the update), after which
// S_DONE hands over the result. An item runs at most max_iterations escape tests (the
// completed iterations, plus one when the point escapes). The input is stalled while
// an item is in flight; a finished result waits in the output register and does not
// block the next item. Config writes are always accepted and must only be issued while
// the core is idle.
module mandelbrot_escape_time_core
  import mbet_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pix_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  localparam int unsigned CMP_W = (FRAC_BITS + 4 > 34) ? FRAC_BITS + 4 : 34;
  localparam logic signed [CMP_W-1:0] FOUR = CMP_W'(4) << FRAC_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CR    = 4'd1;
  localparam logic [3:0] S_CI    = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_MRR   = 4'd4;
  localparam logic [3:0] S_MII   = 4'd5;
  localparam logic [3:0] S_MRI   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic signed [VAL_W-1:0] real_origin_q, imag_origin_q;
  logic [STEP_W-1:0]       real_step_q, imag_step_q;
  logic [ITER_W-1:0]       max_iter_q;

  logic [3:0]              state_q, state_d;
  logic [COORD_W-1:0]      col_q, row_q;
  logic [ITER_W-1:0]       count_q, count_d;
  logic                    esc_q, esc_d;
  logic signed [VAL_W-1:0] cr_q, ci_q, zr_q, zi_q, zr2_q, zi2_q;
  logic signed [VAL_W-1:0] cr_d, ci_d, zr_d, zi_d, zr2_d, zi2_d;

  logic                    out_valid_q, out_valid_d;
  pix_out_t                out_q, out_d;

  logic signed [VAL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] sq_shift, cross_shift;
  logic signed [VAL_W-1:0]  xterm;
  logic signed [CMP_W-1:0]  mag;
  logic                     in_acc, out_take, escape;

  mbet_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= REAL_ORIGIN_RST;
      imag_origin_q <= IMAG_ORIGIN_RST;
      real_step_q   <= REAL_STEP_RST;
      imag_step_q   <= IMAG_STEP_RST;
      max_iter_q    <= MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_REAL_ORIGIN: real_origin_q <= cfg_data_i;
        REG_IMAG_ORIGIN: imag_origin_q <= cfg_data_i;
        REG_REAL_STEP:   real_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_IMAG_STEP:   imag_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_MAX_ITER:    max_iter_q    <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = zr_q;
    mul_b = zi_q;
    unique case (state_q)
      S_CR: begin
        mul_a = VAL_W'(col_q);
        mul_b = VAL_W'(real_step_q);
      end
      S_CI: begin
        mul_a = VAL_W'(row_q);
        mul_b = VAL_W'(imag_step_q);
      end
      S_MRR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_MII: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: ;
    endcase
  end

  assign sq_shift    = prod >>> FRAC_BITS;
  assign cross_shift = prod >>> (FRAC_BITS - 1);
  assign xterm       = sat32(cross_shift);
  assign mag         = CMP_W'(zr2_q) + CMP_W'(zi2_q);
  assign escape      = mag > FOUR;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    esc_d   = esc_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    zr2_d   = zr2_q;
    zi2_d   = zi2_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CR;
        end
      end
      S_CR: state_d = S_CI;
      S_CI: begin
        cr_d    = sat32(PROD_W'(real_origin_q) + prod);
        state_d = S_CINIT;
      end
      S_CINIT: begin
        ci_d    = sat32(PROD_W'(imag_origin_q) - prod);
        zr_d    = cr_q;
        zi_d    = ci_d;
        count_d = '0;
        esc_d   = 1'b0;
        state_d = (max_iter_q == '0) ? S_DONE : S_MRR;
      end
      S_MRR: state_d = S_MII;
      S_MII: begin
        zr2_d   = sat32(sq_shift);
        state_d = S_MRI;
      end
      S_MRI: begin
        zi2_d   = sat32(sq_shift);
        state_d = S_UPD;
      end
      S_UPD: begin
        if (escape) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          zi_d    = sat32(PROD_W'(xterm) + PROD_W'(ci_q));
          zr_d    = sat32(PROD_W'(zr2_q) - PROD_W'(zi2_q) + PROD_W'(cr_q));
          count_d = count_q + 1'b1;
          state_d = (count_d == max_iter_q) ? S_DONE : S_MRR;
        end
      end
      S_DONE: begin
        if (out_take) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_take) begin
      out_valid_d      = 1'b1;
      out_d.out_col    = col_q;
      out_d.out_row    = row_q;
      out_d.iter_count = count_q;
      out_d.escaped    = esc_q;
      out_d.gray_level = GRAY_WHITE - {count_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= in_data_i.pixel_col;
      row_q <= in_data_i.pixel_row;
    end
    count_q <= count_d;
    esc_q   <= esc_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    zr2_q   <= zr2_d;
    zi2_q   <= zi2_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  a_gray_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gray_level == GRAY_WHITE - {out_data_o.iter_count, 1'b0})
    else $error("gray level inconsistent with iteration count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the done state");
`endif

endmodule
